// ----- rtl/core/dnn_pkg.sv -----
package dnn_pkg;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_TYPE     = 3'd1;
    localparam logic [2:0] STATUS_SHORT    = 3'd2;
    localparam logic [2:0] STATUS_LABEL    = 3'd3;
    localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    localparam logic [7:0] MIN_LABEL_RESET = 8'd1;
    localparam logic [7:0] MAX_LABEL_RESET = 8'd100;

    localparam logic REG_MIN_LABEL = 1'b0;
    localparam logic REG_MAX_LABEL = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_of_element;
        logic [7:0]  expected_type;
        logic [15:0] bytes_available;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       end_flag;
        logic [2:0] status;
        logic [8:0] bytes_consumed;
        logic [7:0] element_length;
    } out_item_t;

endpackage

// ----- rtl/core/dnn_label_decoder.sv -----
// A result appears in the output register in the cycle after its byte is transferred.
// Throughput: one byte per cycle; the single decode pass sits between the accepted byte and
// the output register, and input stalls only while a result waits unclaimed downstream.
// Reset (rst_n, asynchronous, active low) returns the decoder to idle, clears all counters
// and loads the label length limits with 1 and 100.
module dnn_label_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dnn_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dnn_pkg::out_item_t  out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_FIRST = 3'd2;
    localparam logic [2:0] PH_LABEL = 3'd3;
    localparam logic [2:0] PH_NEXT  = 3'd4;

    logic [7:0]  min_len_reg;
    logic [7:0]  max_len_reg;

    logic [2:0]  phase_reg,    phase_next;
    logic [7:0]  content_reg,  content_next;
    logic [7:0]  left_reg,     left_next;
    logic [7:0]  name_reg,     name_next;
    logic [8:0]  consumed_reg, consumed_next;
    logic [15:0] avail_reg,    avail_next;

    logic               out_valid_reg;
    dnn_pkg::out_item_t out_reg;
    dnn_pkg::out_item_t res_next;
    logic               emit_next;

    logic in_fire;
    logic [15:0] remaining;
    logic [9:0]  name_sum;
    logic done;
    logic do_adv;
    logic [7:0] adv_char;
    logic adv_cv;

    assign pready   = 1'b1;
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == dnn_pkg::REG_MAX_LABEL)
        begin
            prdata = {24'd0, max_len_reg};
        end
        else
        begin
            prdata = {24'd0, min_len_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= dnn_pkg::MIN_LABEL_RESET;
            max_len_reg <= dnn_pkg::MAX_LABEL_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == dnn_pkg::REG_MIN_LABEL)
            begin
                min_len_reg <= pwdata[7:0];
            end
            else
            begin
                max_len_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        content_next  = content_reg;
        left_next     = left_reg;
        name_next     = name_reg;
        consumed_next = consumed_reg;
        avail_next    = avail_reg;
        emit_next     = 1'b0;
        res_next      = '0;
        done          = 1'b0;
        do_adv        = 1'b0;
        adv_char      = 8'd0;
        adv_cv        = 1'b0;
        remaining     = 16'd0;
        name_sum      = 10'd0;

        if (in_data.start_of_element)
        begin
            content_next  = 8'd0;
            left_next     = 8'd0;
            name_next     = 8'd0;
            consumed_next = 9'd0;
            avail_next    = in_data.bytes_available;
            phase_next    = PH_LEN;
            if (in_data.expected_type != 8'd0)
            begin
                consumed_next = 9'd1;
                done          = 1'b1;
                if (in_data.data_byte != in_data.expected_type)
                begin
                    phase_next        = PH_IDLE;
                    emit_next         = 1'b1;
                    res_next.end_flag = 1'b1;
                    res_next.status   = dnn_pkg::STATUS_TYPE;
                end
            end
        end

        if (!done)
        begin
            unique case (phase_next)
                PH_LEN:
                begin
                    consumed_next = consumed_next + 9'd1;
                    content_next  = in_data.data_byte;
                    remaining = (avail_next > {7'd0, consumed_next})
                              ? avail_next - {7'd0, consumed_next} : 16'd0;
                    if (remaining < {8'd0, in_data.data_byte})
                    begin
                        phase_next        = PH_IDLE;
                        emit_next         = 1'b1;
                        res_next.end_flag = 1'b1;
                        res_next.status   = dnn_pkg::STATUS_SHORT;
                    end
                    else
                    begin
                        phase_next = PH_FIRST;
                    end
                end
                PH_FIRST:
                begin
                    consumed_next = consumed_next + 9'd1;
                    if (in_data.data_byte >= content_next
                        || in_data.data_byte < min_len_reg
                        || in_data.data_byte > max_len_reg)
                    begin
                        phase_next        = PH_IDLE;
                        emit_next         = 1'b1;
                        res_next.end_flag = 1'b1;
                        res_next.status   = dnn_pkg::STATUS_LABEL;
                    end
                    else
                    begin
                        left_next = in_data.data_byte;
                        name_next = 8'd0;
                        do_adv    = 1'b1;
                    end
                end
                PH_LABEL:
                begin
                    consumed_next = consumed_next + 9'd1;
                    name_next     = name_next + 8'd1;
                    left_next     = left_next - 8'd1;
                    do_adv        = 1'b1;
                    adv_char      = in_data.data_byte;
                    adv_cv        = 1'b1;
                end
                PH_NEXT:
                begin
                    consumed_next = consumed_next + 9'd1;
                    name_sum = {2'd0, name_next} + 10'd1 + {2'd0, in_data.data_byte};
                    if (name_sum > 10'd255)
                    begin
                        phase_next        = PH_IDLE;
                        emit_next         = 1'b1;
                        res_next.end_flag = 1'b1;
                        res_next.status   = dnn_pkg::STATUS_OVERFLOW;
                    end
                    else
                    begin
                        name_next = name_next + 8'd1;
                        left_next = in_data.data_byte;
                        do_adv    = 1'b1;
                        adv_char  = dnn_pkg::DOT_CHAR;
                        adv_cv    = 1'b1;
                    end
                end
                default:
                begin
                    // A byte outside an element is dropped.
                end
            endcase
        end

        // After a character or a label length the element either ends or carries on.
        if (do_adv)
        begin
            res_next.out_char   = adv_char;
            res_next.char_valid = adv_cv;
            if (left_next == 8'd0 && !(({1'b0, name_next} + 9'd1) < {1'b0, content_next}))
            begin
                phase_next              = PH_IDLE;
                emit_next               = 1'b1;
                res_next.end_flag       = 1'b1;
                res_next.status         = dnn_pkg::STATUS_OK;
                res_next.bytes_consumed = consumed_next;
            end
            else
            begin
                phase_next = (left_next != 8'd0) ? PH_LABEL : PH_NEXT;
                emit_next  = adv_cv;
            end
        end

        res_next.element_length = content_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            content_reg   <= 8'd0;
            left_reg      <= 8'd0;
            name_reg      <= 8'd0;
            consumed_reg  <= 9'd0;
            avail_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                content_reg   <= content_next;
                left_reg      <= left_next;
                name_reg      <= name_next;
                consumed_reg  <= consumed_next;
                avail_reg     <= avail_next;
                out_valid_reg <= emit_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result register is loaded only when a transfer produces a result.
    always_ff @(posedge clk)
    begin
        if (in_fire && emit_next)
        begin
            out_reg <= res_next;
        end
    end

endmodule
